/* hw/rtl/ppue_pkg.sv */
// ----------------------------------------------------------------------------
// ppue_pkg
// shared types and constants of the particle pool update engine
// ----------------------------------------------------------------------------
package ppue_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [0:0] REG_DRAG_SPARK = 1'b0;
    localparam logic [0:0] REG_DRAG_OTHER = 1'b1;

    localparam logic [15:0] DRAG_SPARK_RST = 16'd10240;
    localparam logic [15:0] DRAG_OTHER_RST = 16'd7373;
    localparam logic [2:0]  KIND_SPARK     = 3'd0;

    // packed pool entry, 259 bits
    typedef struct packed {
        logic [23:0] px;
        logic [23:0] py;
        logic [23:0] vx;
        logic [23:0] vy;
        logic [23:0] rot;
        logic [23:0] spin;
        logic [15:0] life;
        logic [15:0] decay;
        logic [15:0] size;
        logic [2:0]  kind;
        logic [63:0] colors;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,       // issue read of entry i
        ST_RDWAIT,   // read data registered
        ST_LOSS,     // loss = decay*dt
        ST_FACT,     // drag*dt -> factor
        ST_VX,       // vx*factor
        ST_VY,       // vy*factor
        ST_PX,       // vx'*dt
        ST_PY,       // vy'*dt
        ST_ROT,      // spin*dt
        ST_WB,       // write back entry i
        ST_MOVE,     // copy last entry into slot i
        ST_OUT
    } state_t;

    function automatic logic [23:0] sat24(input logic signed [25:0] v);
        if (v > 26'sd8388607)       sat24 = 24'h7FFFFF;
        else if (v < -26'sd8388608) sat24 = 24'h800000;
        else                        sat24 = v[23:0];
    endfunction

endpackage

/* hw/rtl/particle_pool_update_engine_core.sv */
// ----------------------------------------------------------------------------
// particle_pool_update_engine_core
// bounded particle pool with add, tick, read and clear operations
// ----------------------------------------------------------------------------
// Use: an operation word is taken on s_valid/s_ready, the result word is
// given on m_valid/m_ready, and drag registers are written on the cfg
// channel (cfg_index 0 spark, 1 other) while the block is idle.
// s_ready and cfg_ready are high only in idle; one operation is in flight.
// Add, clear and a zero-step tick raise m_valid in the cycle after
// acceptance; read passes through ST_RDWAIT (one registered pool read) first.
// Tick walks the live entries through one shared 25x18 multiplier, seven
// products per surviving entry and two per removed one, followed by a
// closing ST_RD; the walk of a full pool of 1024 entries is paced by
// the single multiplier and the single read port of the pool memory.
// No new word is taken, for add, clear or read, until the result of the
// last one has left on m_valid/m_ready.
// The result sits in the state register until m_ready; a stalled receiver
// holds the block in that state with s_ready low.
// Reset empties the pool (count to zero), loads the drag defaults and
// leaves the pool memory as is; no clearing pass is needed.
// ----------------------------------------------------------------------------
module particle_pool_update_engine_core
    import ppue_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [16:0] s_step_time,
    input  logic [9:0]  s_read_index,
    input  logic [47:0] s_position,
    input  logic [47:0] s_velocity,
    input  logic signed [23:0] s_rotation,
    input  logic signed [23:0] s_spin,
    input  logic [15:0] s_life,
    input  logic [15:0] s_decay_rate,
    input  logic [15:0] s_particle_size,
    input  logic [2:0]  s_kind,
    input  logic [63:0] s_colors,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_add_ok,
    output logic [10:0] m_active_count,
    output logic        m_is_empty,
    output logic [47:0] m_out_position,
    output logic [47:0] m_out_velocity,
    output logic signed [23:0] m_out_rotation,
    output logic signed [23:0] m_out_spin,
    output logic [15:0] m_out_life,
    output logic [15:0] m_out_decay,
    output logic [15:0] m_out_size,
    output logic [2:0]  m_out_kind,
    output logic [63:0] m_out_colors
);

    entry_t mem [POOL_DEPTH];
    entry_t rd_data_reg;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [15:0] drag_spark_reg, drag_other_reg;
    logic [16:0] dt_reg, dt_next;
    logic [1:0]  op_reg, op_next;
    logic        add_ok_reg, add_ok_next;
    logic        rd_hit_reg, rd_hit_next;
    entry_t      cur_reg, cur_next;
    logic signed [41:0] prod_reg;
    logic [16:0] factor_reg, factor_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [IDX_W-1:0]  rd_addr;

    // shared multiplier: signed 25 x unsigned 17
    logic signed [24:0] mul_a;
    logic [16:0]        mul_b;
    logic signed [41:0] mul_p;

    logic [CNT_W-1:0] last;
    logic signed [20:0] life_new;
    logic signed [21:0] fact_raw;
    logic [16:0] fact_clamp;
    logic [16:0] dt_sat;

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    // loss = (decay*dt) >> 13, drag term = (drag*dt) >> 12
    assign last       = count_reg - 1'b1;
    assign life_new   = $signed({5'b00000, cur_reg.life}) - $signed({2'b00, prod_reg[31:13]});
    assign fact_raw   = 22'sd65536 - $signed({2'b00, prod_reg[31:12]});
    assign fact_clamp = fact_raw[21] ? 17'd0 : fact_raw[16:0];
    assign dt_sat     = (s_step_time > 17'd65536) ? 17'd65536 : s_step_time;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            drag_spark_reg <= DRAG_SPARK_RST;
            drag_other_reg <= DRAG_OTHER_RST;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_DRAG_SPARK) drag_spark_reg <= cfg_data;
                else                             drag_other_reg <= cfg_data;
            end
        end
        i_reg      <= i_next;
        dt_reg     <= dt_next;
        op_reg     <= op_next;
        add_ok_reg <= add_ok_next;
        rd_hit_reg <= rd_hit_next;
        cur_reg    <= cur_next;
        factor_reg <= factor_next;
        prod_reg   <= mul_p;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_TICK && dt_sat != 17'd0) state_next = ST_RD;
                    else if (s_operation == OP_READ)              state_next = ST_RDWAIT;
                    else                                          state_next = ST_OUT;
                end
            end
            ST_RD:     state_next = (i_reg < count_reg) ? ST_RDWAIT : ST_OUT;
            ST_RDWAIT: state_next = (op_reg == OP_READ) ? ST_OUT : ST_LOSS;
            ST_LOSS:   state_next = ST_FACT;
            ST_FACT:   state_next = (life_new <= 21'sd0) ? ST_MOVE : ST_VX;
            ST_VX:     state_next = ST_VY;
            ST_VY:     state_next = ST_PX;
            ST_PX:     state_next = ST_PY;
            ST_PY:     state_next = ST_ROT;
            ST_ROT:    state_next = ST_WB;
            ST_WB:     state_next = ST_RD;
            ST_MOVE:   state_next = (i_reg == last) ? ST_RD : ST_RDWAIT;
            ST_OUT:    state_next = m_ready ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        count_next  = count_reg;
        i_next      = i_reg;
        dt_next     = dt_reg;
        op_next     = op_reg;
        add_ok_next = add_ok_reg;
        rd_hit_next = rd_hit_reg;
        cur_next    = cur_reg;
        factor_next = factor_reg;
        wr_en       = 1'b0;
        wr_addr     = i_reg[IDX_W-1:0];
        wr_data     = cur_reg;
        rd_addr     = i_reg[IDX_W-1:0];
        mul_a       = '0;
        mul_b       = dt_reg;
        case (state_reg)
            ST_IDLE: begin
                op_next     = s_operation;
                dt_next     = dt_sat;
                i_next      = '0;
                add_ok_next = 1'b0;
                rd_hit_next = ({1'b0, s_read_index} < count_reg);
                rd_addr     = s_read_index[IDX_W-1:0];
                if (s_valid) begin
                    if (s_operation == OP_ADD && count_reg < CNT_W'(POOL_DEPTH)) begin
                        wr_en          = 1'b1;
                        wr_addr        = count_reg[IDX_W-1:0];
                        wr_data.px     = s_position[47:24];
                        wr_data.py     = s_position[23:0];
                        wr_data.vx     = s_velocity[47:24];
                        wr_data.vy     = s_velocity[23:0];
                        wr_data.rot    = s_rotation;
                        wr_data.spin   = s_spin;
                        wr_data.life   = s_life;
                        wr_data.decay  = s_decay_rate;
                        wr_data.size   = s_particle_size;
                        wr_data.kind   = s_kind;
                        wr_data.colors = s_colors;
                        count_next     = count_reg + 1'b1;
                        add_ok_next    = 1'b1;
                    end else if (s_operation == OP_CLEAR) begin
                        count_next = '0;
                    end
                end
            end
            ST_RD: ;
            ST_RDWAIT: begin
                cur_next = rd_data_reg;
            end
            ST_LOSS: begin
                mul_a = $signed({9'd0, cur_reg.decay});
            end
            ST_FACT: begin
                mul_a = $signed({9'd0, (cur_reg.kind == KIND_SPARK) ?
                                        drag_spark_reg : drag_other_reg});
                cur_next.life = life_new[15:0];
            end
            ST_VX: begin
                factor_next = fact_clamp;
                mul_a = $signed({cur_reg.vx[23], cur_reg.vx});
                mul_b = fact_clamp;
            end
            ST_VY: begin
                cur_next.vx = prod_reg[39:16];
                mul_a = $signed({cur_reg.vy[23], cur_reg.vy});
                mul_b = factor_reg;
            end
            ST_PX: begin
                cur_next.vy = prod_reg[39:16];
                mul_a = $signed({cur_reg.vx[23], cur_reg.vx});
            end
            ST_PY: begin
                cur_next.px = sat24($signed({{2{cur_reg.px[23]}}, cur_reg.px}) +
                                    $signed(prod_reg[41:16]));
                mul_a = $signed({cur_reg.vy[23], cur_reg.vy});
            end
            ST_ROT: begin
                cur_next.py = sat24($signed({{2{cur_reg.py[23]}}, cur_reg.py}) +
                                    $signed(prod_reg[41:16]));
                mul_a = $signed({cur_reg.spin[23], cur_reg.spin});
            end
            ST_WB: begin
                wr_en    = 1'b1;
                wr_data  = cur_reg;
                wr_data.rot = sat24($signed({{2{cur_reg.rot[23]}}, cur_reg.rot}) +
                                    $signed(prod_reg[41:16]));
                i_next   = i_reg + 1'b1;
            end
            ST_MOVE: begin
                // last entry is read into the working word for slot i
                count_next = last;
                rd_addr    = last[IDX_W-1:0];
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_comb begin
        m_add_ok       = add_ok_reg;
        m_active_count = 11'(count_reg);
        m_is_empty     = (count_reg == '0);
        m_out_position = '0;
        m_out_velocity = '0;
        m_out_rotation = '0;
        m_out_spin     = '0;
        m_out_life     = '0;
        m_out_decay    = '0;
        m_out_size     = '0;
        m_out_kind     = '0;
        m_out_colors   = '0;
        if (op_reg == OP_READ && rd_hit_reg) begin
            m_out_position = {cur_reg.px, cur_reg.py};
            m_out_velocity = {cur_reg.vx, cur_reg.vy};
            m_out_rotation = cur_reg.rot;
            m_out_spin     = cur_reg.spin;
            m_out_life     = cur_reg.life;
            m_out_decay    = cur_reg.decay;
            m_out_size     = cur_reg.size;
            m_out_kind     = cur_reg.kind;
            m_out_colors   = cur_reg.colors;
        end
    end

endmodule
